@@ hw/rtl/meuf_pkg.sv @@
// Shared widths, reset values and constants for the motor encoder unwrap filter.
// No dependencies; every other file of the block refers to it by scoped names.
package meuf_pkg;

  localparam int POS_W   = 16;
  localparam int SPEED_W = 16;
  localparam int CURR_W  = 16;
  localparam int TEMP_W  = 8;
  localparam int RATE_W  = 17;
  localparam int TURN_W  = 16;
  localparam int ANGLE_W = 35;
  localparam int THR_W   = 13;

  localparam logic [THR_W-1:0] THR_RESET = 13'd6000;

  localparam int RATE_DEPTH_DEF = 8;

  localparam logic signed [17:0] TURN_SPAN = 18'sd8192;
  localparam int TURN_SPAN_LOG2 = 13;
  localparam logic signed [35:0] ANGLE_SCALE = 36'sd45;

  localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

  localparam logic signed [RATE_W-1:0] RATE_ABS_MAX = 17'sd65535;

endpackage

@@ hw/rtl/meuf_in_if.sv @@
// Input channel of the motor encoder unwrap filter: one feedback frame per transaction.
// Depends on meuf_pkg for the field widths.
interface meuf_in_if;
  logic                             valid;
  logic                             ready;
  logic [meuf_pkg::POS_W-1:0]       encoder_position;
  logic [meuf_pkg::SPEED_W-1:0]     speed_raw;
  logic [meuf_pkg::CURR_W-1:0]      current_raw;
  logic [meuf_pkg::TEMP_W-1:0]      temperature;

  modport source (output valid, encoder_position, speed_raw, current_raw, temperature,
                  input ready);
  modport sink (input valid, encoder_position, speed_raw, current_raw, temperature,
                output ready);
endinterface

@@ hw/rtl/meuf_out_if.sv @@
// Result channel of the motor encoder unwrap filter: one filtered frame per transaction.
// Depends on meuf_pkg for the field widths.
interface meuf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [meuf_pkg::RATE_W-1:0]  step_rate;
  logic signed [meuf_pkg::RATE_W-1:0]  average_rate;
  logic signed [meuf_pkg::TURN_W-1:0]  turn_count;
  logic signed [meuf_pkg::ANGLE_W-1:0] angle_q10;
  logic [meuf_pkg::SPEED_W-1:0]        speed_out;
  logic [meuf_pkg::CURR_W-1:0]         current_out;
  logic [meuf_pkg::TEMP_W-1:0]         temperature_out;

  modport source (output valid, step_rate, average_rate, turn_count, angle_q10, speed_out,
                  current_out, temperature_out, input ready);
  modport sink (input valid, step_rate, average_rate, turn_count, angle_q10, speed_out,
                current_out, temperature_out, output ready);
endinterface

@@ hw/rtl/motor_encoder_unwrap_filter.sv @@
// Top level of the motor encoder unwrap filter: input register, unwrap/filter logic,
// result register. Depends on meuf_pkg, meuf_in_if and meuf_out_if.

// Each feedback frame is captured in an input register and then unwrapped, filtered and
// written to the result register when that register is empty or being read, and a new
// frame is accepted every cycle while results are taken. The first frame after reset
// sets the zero bias. A position step beyond +/- wrap_threshold counts as a turn wrap;
// the turn count saturates. The average covers the last RATE_DEPTH rates (zeros after
// reset), truncated toward zero; angle_q10 is degrees with ten fraction bits. Write
// cfg_wr_data only while no frame is in flight.
module motor_encoder_unwrap_filter #(
  parameter int RATE_DEPTH = meuf_pkg::RATE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [meuf_pkg::THR_W-1:0]   cfg_wr_data,
  meuf_in_if.sink                      in_frame,
  meuf_out_if.source                   out_result
);

  localparam int DEPTH_L   = $clog2(RATE_DEPTH);
  localparam int IDX_W     = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int SUM_MAG_W = meuf_pkg::RATE_W - 1 + DEPTH_L;
  localparam int SUM_W     = SUM_MAG_W + 1;
  localparam int DIV_K     = SUM_MAG_W + DEPTH_L;
  localparam int DIV_M_W   = SUM_MAG_W + 1;
  localparam int PROD_W    = SUM_MAG_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'((64'd1 << DIV_K) / RATE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RATE_DEPTH - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX =
    SUM_W'(RATE_DEPTH) * SUM_W'(meuf_pkg::RATE_ABS_MAX);

  // input register
  logic                               s1_vld_r;
  logic [meuf_pkg::POS_W-1:0]         s1_pos_r;
  logic [meuf_pkg::SPEED_W-1:0]       s1_speed_r;
  logic [meuf_pkg::CURR_W-1:0]        s1_curr_r;
  logic [meuf_pkg::TEMP_W-1:0]        s1_temp_r;

  // block state
  logic [meuf_pkg::THR_W-1:0]         thr_r;
  logic                               started_r;
  logic [meuf_pkg::POS_W-1:0]         bias_r;
  logic [meuf_pkg::POS_W-1:0]         cur_pos_r;
  logic [meuf_pkg::POS_W-1:0]         prev_pos_r;
  logic signed [meuf_pkg::TURN_W-1:0] turns_r;
  logic signed [SUM_W-1:0]            sum_r;
  logic [IDX_W-1:0]                   idx_r;
  logic [RATE_DEPTH-1:0]              ring_vld_r;
  logic signed [meuf_pkg::RATE_W-1:0] ring_old_r;
  logic signed [meuf_pkg::RATE_W-1:0] ring_mem [RATE_DEPTH];

  // result register
  logic                                out_vld_r;
  logic signed [meuf_pkg::RATE_W-1:0]  out_rate_r;
  logic signed [meuf_pkg::RATE_W-1:0]  out_avg_r;
  logic signed [meuf_pkg::TURN_W-1:0]  out_turns_r;
  logic signed [meuf_pkg::ANGLE_W-1:0] out_angle_r;
  logic [meuf_pkg::SPEED_W-1:0]        out_speed_r;
  logic [meuf_pkg::CURR_W-1:0]         out_curr_r;
  logic [meuf_pkg::TEMP_W-1:0]         out_temp_r;

  // datapath
  logic                               fire;
  logic                               s1_vld_nxt;
  logic                               out_vld_nxt;
  logic [meuf_pkg::POS_W-1:0]         bias_nxt;
  logic [meuf_pkg::POS_W-1:0]         prev_pos_nxt;
  logic signed [meuf_pkg::RATE_W-1:0] diff;
  logic signed [meuf_pkg::RATE_W-1:0] thr_s;
  logic                               wrap_up;
  logic                               wrap_dn;
  logic signed [17:0]                 rate_w;
  logic signed [meuf_pkg::RATE_W-1:0] rate;
  logic signed [meuf_pkg::TURN_W-1:0] turns_nxt;
  logic signed [SUM_W-1:0]            sum_nxt;
  logic [IDX_W-1:0]                   idx_nxt;
  logic                               sum_neg;
  logic [SUM_MAG_W-1:0]               sum_mag;
  logic [PROD_W-1:0]                  div_prod;
  logic [meuf_pkg::RATE_W-1:0]        avg_mag;
  logic signed [meuf_pkg::RATE_W-1:0] avg;
  logic signed [meuf_pkg::RATE_W-1:0] pos_rel;
  logic signed [29:0]                 turn_pos;
  logic signed [29:0]                 ang_base;
  logic signed [35:0]                 ang_full;

  assign fire          = s1_vld_r && (!out_vld_r || out_result.ready);
  assign in_frame.ready = !s1_vld_r || fire;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_frame.valid && in_frame.ready) begin
      s1_vld_nxt = 1'b1;
    end else if (fire) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_result.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    if (!started_r) begin
      bias_nxt     = s1_pos_r;
      prev_pos_nxt = s1_pos_r;
    end else begin
      bias_nxt     = bias_r;
      prev_pos_nxt = (s1_pos_r != cur_pos_r) ? cur_pos_r : prev_pos_r;
    end

    diff    = $signed({1'b0, s1_pos_r}) - $signed({1'b0, prev_pos_nxt});
    thr_s   = $signed({4'b0, thr_r});
    wrap_up = diff < -thr_s;
    wrap_dn = diff > thr_s;

    turns_nxt = turns_r;
    rate_w    = 18'(diff);
    if (wrap_up) begin
      rate_w = 18'(diff) + meuf_pkg::TURN_SPAN;
      if (turns_r != meuf_pkg::TURN_MAX) begin
        turns_nxt = turns_r + 16'sd1;
      end
    end else if (wrap_dn) begin
      rate_w = 18'(diff) - meuf_pkg::TURN_SPAN;
      if (turns_r != meuf_pkg::TURN_MIN) begin
        turns_nxt = turns_r - 16'sd1;
      end
    end
    rate = rate_w[meuf_pkg::RATE_W-1:0];

    sum_nxt = sum_r + SUM_W'(rate) - SUM_W'(ring_old_r);
    idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

    // truncate toward zero: divide the magnitude by reciprocal multiply, restore the sign
    sum_neg  = sum_nxt[SUM_W-1];
    sum_mag  = sum_neg ? SUM_MAG_W'(-sum_nxt) : SUM_MAG_W'(sum_nxt);
    div_prod = PROD_W'(sum_mag) * PROD_W'(DIV_M);
    avg_mag  = div_prod[PROD_W-1:DIV_K];
    avg      = sum_neg ? -$signed(avg_mag) : $signed(avg_mag);

    pos_rel  = $signed({1'b0, s1_pos_r}) - $signed({1'b0, bias_nxt});
    turn_pos = {turns_nxt[meuf_pkg::TURN_W-1], turns_nxt,
                {meuf_pkg::TURN_SPAN_LOG2{1'b0}}};
    ang_base = 30'(pos_rel) + turn_pos;
    ang_full = 36'(ang_base) * meuf_pkg::ANGLE_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_frame.valid && in_frame.ready) begin
      s1_pos_r   <= in_frame.encoder_position;
      s1_speed_r <= in_frame.speed_raw;
      s1_curr_r  <= in_frame.current_raw;
      s1_temp_r  <= in_frame.temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= meuf_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      bias_r     <= '0;
      cur_pos_r  <= '0;
      prev_pos_r <= '0;
      turns_r    <= '0;
      sum_r      <= '0;
      idx_r      <= '0;
    end else if (fire) begin
      started_r  <= 1'b1;
      bias_r     <= bias_nxt;
      cur_pos_r  <= s1_pos_r;
      prev_pos_r <= prev_pos_nxt;
      turns_r    <= turns_nxt;
      sum_r      <= sum_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // rate ring: entries not yet written read as zero; prefetch the entry leaving next
  always_ff @(posedge clk) begin
    if (fire) begin
      ring_mem[idx_r] <= rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      ring_old_r <= '0;
    end else if (fire) begin
      ring_vld_r[idx_r] <= 1'b1;
      if (idx_nxt == idx_r) begin
        ring_old_r <= rate;
      end else if (ring_vld_r[idx_nxt]) begin
        ring_old_r <= ring_mem[idx_nxt];
      end else begin
        ring_old_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rate_r  <= rate;
      out_avg_r   <= avg;
      out_turns_r <= turns_nxt;
      out_angle_r <= ang_full[meuf_pkg::ANGLE_W-1:0];
      out_speed_r <= s1_speed_r;
      out_curr_r  <= s1_curr_r;
      out_temp_r  <= s1_temp_r;
    end
  end

  assign out_result.valid           = out_vld_r;
  assign out_result.step_rate       = out_rate_r;
  assign out_result.average_rate    = out_avg_r;
  assign out_result.turn_count      = out_turns_r;
  assign out_result.angle_q10       = out_angle_r;
  assign out_result.speed_out       = out_speed_r;
  assign out_result.current_out     = out_curr_r;
  assign out_result.temperature_out = out_temp_r;

  a_first_frame_bias: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !started_r |=> started_r && bias_r == cur_pos_r && prev_pos_r == cur_pos_r)
    else $error("first frame did not set bias and previous position");

  a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_MAX && sum_r >= -SUM_MAX)
    else $error("ring sum out of range");

  a_turns_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    fire && wrap_up && turns_r == meuf_pkg::TURN_MAX |=> turns_r == meuf_pkg::TURN_MAX)
    else $error("turn count wrapped past its maximum");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed frame did not reach the result register");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !fire |=> s1_vld_r && $stable(s1_pos_r))
    else $error("stalled frame lost from the input register");

endmodule
